/* rtl/core/sghb_pkg.sv */
// Shared constants, types and helper functions of the hat basis unit.
`default_nettype none
package sghb_pkg;

	localparam int MAX_GRID_POINTS = 1024;
	localparam int MAX_DIMS        = 8;
	localparam int GP_W            = $clog2(MAX_GRID_POINTS);
	localparam int DIM_W           = $clog2(MAX_DIMS);
	localparam int LUT_AW          = GP_W + DIM_W;
	localparam int ACC_W           = 48;
	localparam int LEV_MAX         = 16;

	// One in Q1.16.
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// Input item modes.
	localparam logic [1:0] MODE_GRID    = 2'd0;
	localparam logic [1:0] MODE_SURPLUS = 2'd1;
	localparam logic [1:0] MODE_COORD   = 2'd2;
	localparam logic [1:0] MODE_RDCLR   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GRID_POINTS = 2'd0;
	localparam logic [1:0] CFG_DIMS        = 2'd1;
	localparam logic [1:0] CFG_DIRECTION   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              take;
		logic              acc_rd;
		logic [GP_W-1:0]   acc_raddr;
		logic              acc_we;
		logic [GP_W-1:0]   acc_waddr;
		logic              acc_wsel_sum;
		logic              lut_rd;
		logic [LUT_AW-1:0] lut_addr;
		logic [DIM_W-1:0]  dim_sel;
		logic              hat_en;
		logic              basis_init;
		logic              basis_mul;
		logic              prod_en;
		logic              sum_clr;
		logic              sum_add;
		logic              dir;
		logic              out_load;
		logic              out_sel_walk;
		logic [GP_W-1:0]   rc_point;
	} sghb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
	} sghb_sts_t;

	// Saturate a 49-bit sum to the signed 48-bit range.
	function automatic logic [ACC_W-1:0] sat48(input logic [ACC_W:0] s);
		logic [ACC_W-1:0] r;
		if (s[ACC_W] != s[ACC_W-1]) begin
			r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = s[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/sghb_datapath.sv */
// Datapath: grid tables, accumulators, hat and basis arithmetic, result register.
`default_nettype none
module sghb_datapath (
	input  wire                        clk,
	input  wire                        arst_n,
	input  sghb_pkg::sghb_cmd_t        cmd,
	output sghb_pkg::sghb_sts_t        sts,
	input  wire [1:0]                  mode,
	input  wire [9:0]                  point,
	input  wire [2:0]                  dim,
	input  wire [4:0]                  level_exp,
	input  wire [15:0]                 grid_index,
	input  wire signed [31:0]          weight,
	input  wire [16:0]                 coord,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic signed [47:0]         result_value,
	output logic [15:0]                result_number
);
	import sghb_pkg::*;

	logic [4:0]         level_mem   [0:MAX_GRID_POINTS*MAX_DIMS-1];
	logic [15:0]        index_mem   [0:MAX_GRID_POINTS*MAX_DIMS-1];
	logic signed [31:0] surplus_mem [0:MAX_GRID_POINTS-1];
	logic [ACC_W-1:0]   acc_mem     [0:MAX_GRID_POINTS-1];
	logic [16:0]        coord_q     [0:MAX_DIMS-1];

	logic [4:0]         lvl_rd_q;
	logic [15:0]        idx_rd_q;
	logic signed [31:0] sur_rd_q;
	logic [ACC_W-1:0]   acc_rd_q;
	logic [16:0]        hat_q;
	logic [16:0]        basis_q;
	logic signed [49:0] prod_q;
	logic [ACC_W-1:0]   sum_q;
	logic signed [31:0] point_weight_q;
	logic [15:0]        data_counter_q;
	logic               out_valid_q;
	logic [ACC_W-1:0]   out_value_q;
	logic [15:0]        out_number_q;

	logic [4:0]         lev_clamped;
	logic [16:0]        crd_clamped;
	logic [32:0]        t_pos;
	logic [32:0]        c_pos;
	logic [32:0]        dist_abs;
	logic [16:0]        hat_d;
	logic [33:0]        bprod;
	logic signed [31:0] w_sel;
	logic signed [33:0] term;
	logic [ACC_W:0]     term_x;
	logic [ACC_W-1:0]   acc_new;
	logic [ACC_W-1:0]   sum_new;
	logic               grid_wr;
	logic               sur_wr;
	logic               crd_wr;

	assign grid_wr     = cmd.take && (mode == MODE_GRID);
	assign sur_wr      = cmd.take && (mode == MODE_SURPLUS);
	assign crd_wr      = cmd.take && (mode == MODE_COORD);
	assign lev_clamped = (level_exp > 5'(LEV_MAX)) ? 5'(LEV_MAX) : level_exp;
	assign crd_clamped = (coord > ONE_Q16) ? ONE_Q16 : coord;

	// Level and index tables.
	always_ff @(posedge clk) begin
		if (grid_wr) begin
			level_mem[{point, dim}] <= lev_clamped;
			index_mem[{point, dim}] <= grid_index;
		end
		if (cmd.lut_rd) begin
			lvl_rd_q <= level_mem[cmd.lut_addr];
			idx_rd_q <= index_mem[cmd.lut_addr];
		end
	end

	// Surplus table, read together with the accumulator.
	always_ff @(posedge clk) begin
		if (sur_wr) begin
			surplus_mem[point] <= weight;
		end
		if (cmd.acc_rd) begin
			sur_rd_q <= surplus_mem[cmd.acc_raddr];
		end
	end

	// Per grid point accumulators.
	always_ff @(posedge clk) begin
		if (cmd.acc_we) begin
			acc_mem[cmd.acc_waddr] <= cmd.acc_wsel_sum ? acc_new : '0;
		end
		if (cmd.acc_rd) begin
			acc_rd_q <= acc_mem[cmd.acc_raddr];
		end
	end

	// Coordinate buffer of the current data point.
	always_ff @(posedge clk) begin
		if (crd_wr) begin
			coord_q[dim] <= crd_clamped;
		end
	end

	// Hat value of one dimension.
	always_comb begin
		t_pos    = 33'(coord_q[cmd.dim_sel]) << lvl_rd_q;
		c_pos    = {1'b0, idx_rd_q, 16'h0000};
		dist_abs = (t_pos > c_pos) ? (t_pos - c_pos) : (c_pos - t_pos);
		hat_d    = (dist_abs >= 33'(ONE_Q16)) ? 17'd0 : 17'(33'(ONE_Q16) - dist_abs);
	end

	// Basis product, weighted term and saturating sums.
	assign bprod   = 34'(basis_q) * 34'(hat_q);
	assign w_sel   = cmd.dir ? sur_rd_q : point_weight_q;
	assign term    = prod_q[49:16];
	assign term_x  = {{(ACC_W+1-34){term[33]}}, term};
	assign acc_new = sat48({acc_rd_q[ACC_W-1], acc_rd_q} + term_x);
	assign sum_new = sat48({sum_q[ACC_W-1], sum_q} + term_x);

	always_ff @(posedge clk) begin
		if (cmd.hat_en) begin
			hat_q <= hat_d;
		end
		if (cmd.basis_init) begin
			basis_q <= ONE_Q16;
		end else if (cmd.basis_mul) begin
			basis_q <= bprod[32:16];
		end
		if (cmd.prod_en) begin
			prod_q <= w_sel * $signed({1'b0, basis_q});
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_new;
		end
	end

	// Data weight and data point counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_weight_q <= '0;
			data_counter_q <= '0;
		end else begin
			if (crd_wr) begin
				point_weight_q <= weight;
			end
			if (cmd.out_load && cmd.out_sel_walk) begin
				data_counter_q <= data_counter_q + 16'd1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q  <= cmd.out_sel_walk ? sum_q : acc_rd_q;
			out_number_q <= cmd.out_sel_walk ? data_counter_q : 16'(cmd.rc_point);
		end
	end

	assign sts.slot_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign result_value  = out_value_q;
	assign result_number = out_number_q;

endmodule
`default_nettype wire

/* rtl/core/sghb_ctrl.sv */
// Controller: configuration registers, clearing pass and grid walk sequencer.
`default_nettype none
module sghb_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire [1:0]             mode,
	input  wire [9:0]             point,
	input  wire                   last_dim,
	input  wire                   cfg_we,
	input  wire [1:0]             cfg_index,
	input  wire [10:0]            cfg_data,
	output sghb_pkg::sghb_cmd_t   cmd,
	input  sghb_pkg::sghb_sts_t   sts
);
	import sghb_pkg::*;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RC   = 4'd2;
	localparam logic [3:0] S_PT   = 4'd3;
	localparam logic [3:0] S_RD   = 4'd4;
	localparam logic [3:0] S_HAT  = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_PROD = 4'd7;
	localparam logic [3:0] S_ADD  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0]       state_q, state_d;
	logic [GP_W-1:0]  j_q, j_d;
	logic [DIM_W-1:0] d_q, d_d;
	logic [GP_W-1:0]  pt_q, pt_d;
	logic [10:0]      gp_cfg_q;
	logic [3:0]       dims_cfg_q;
	logic             dir_q;
	logic [10:0]      ng;
	logic [3:0]       nd;
	logic             take;
	logic             last_point;
	logic             last_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_cfg_q   <= 11'(MAX_GRID_POINTS);
			dims_cfg_q <= 4'(MAX_DIMS);
			dir_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_POINTS: gp_cfg_q   <= cfg_data;
				CFG_DIMS:        dims_cfg_q <= cfg_data[3:0];
				CFG_DIRECTION:   dir_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ng = (gp_cfg_q > 11'(MAX_GRID_POINTS)) ? 11'(MAX_GRID_POINTS) : gp_cfg_q;
	assign nd = (dims_cfg_q > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dims_cfg_q;

	assign take       = in_valid && (state_q == S_IDLE);
	assign in_stall   = (state_q != S_IDLE);
	assign last_point = ({1'b0, j_q} == ng - 11'd1);
	assign last_d     = ({1'b0, d_q} == nd - 4'd1);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		d_d     = d_q;
		pt_d    = pt_q;
		cmd              = '0;
		cmd.take         = take;
		cmd.dir          = dir_q;
		cmd.acc_raddr    = (state_q == S_IDLE) ? point : j_q;
		cmd.acc_waddr    = j_q;
		cmd.lut_addr     = {j_q, d_q};
		cmd.dim_sel      = d_q;
		cmd.rc_point     = pt_q;
		unique case (state_q)
			S_CLR: begin
				// Clearing pass over the accumulators after reset.
				cmd.acc_we = 1'b1;
				j_d        = j_q + 1'b1;
				if (j_q == GP_W'(MAX_GRID_POINTS - 1)) begin
					j_d     = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (take) begin
					if (mode == MODE_RDCLR) begin
						cmd.acc_rd = 1'b1;
						pt_d       = point;
						state_d    = S_RC;
					end else if (mode == MODE_COORD && last_dim) begin
						cmd.sum_clr = 1'b1;
						j_d         = '0;
						if (ng == 11'd0) begin
							state_d = dir_q ? S_FIN : S_IDLE;
						end else begin
							state_d = S_PT;
						end
					end
				end
			end
			S_RC: begin
				if (sts.slot_free) begin
					cmd.out_load  = 1'b1;
					cmd.acc_we    = 1'b1;
					cmd.acc_waddr = pt_q;
					state_d       = S_IDLE;
				end
			end
			S_PT: begin
				cmd.acc_rd     = 1'b1;
				cmd.basis_init = 1'b1;
				d_d            = '0;
				state_d        = (nd == 4'd0) ? S_PROD : S_RD;
			end
			S_RD: begin
				cmd.lut_rd = 1'b1;
				state_d    = S_HAT;
			end
			S_HAT: begin
				cmd.hat_en = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.basis_mul = 1'b1;
				if (last_d) begin
					state_d = S_PROD;
				end else begin
					d_d     = d_q + 1'b1;
					state_d = S_RD;
				end
			end
			S_PROD: begin
				cmd.prod_en = 1'b1;
				state_d     = S_ADD;
			end
			S_ADD: begin
				cmd.acc_we       = !dir_q;
				cmd.acc_wsel_sum = 1'b1;
				cmd.sum_add      = dir_q;
				if (last_point) begin
					state_d = dir_q ? S_FIN : S_IDLE;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = S_PT;
				end
			end
			S_FIN: begin
				if (sts.slot_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_sel_walk = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			j_q     <= '0;
			d_q     <= '0;
			pt_q    <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			d_q     <= d_d;
			pt_q    <= pt_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sparse_grid_hat_basis_mult_unit.sv */
// Top level of the sparse grid hat basis unit.
// After reset the unit clears its 1024 accumulators, one a cycle, and holds
// in_stall high while it does so. Table loads and coordinates that are not
// marked last leave the unit idle and ready for the next item; a read-clear
// reads the accumulator, then waits for the result register to be free. A
// coordinate marked last_dim starts a walk over the grid points in use; for
// each point the unit reads the accumulator, then per dimension does a table
// read, hat and basis multiply, then a weight multiply and accumulate. The
// input is stalled during the walk; a finished result waits in the output
// register while the next item is accepted.
`default_nettype none
module sparse_grid_hat_basis_mult_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [1:0]          mode,
	input  wire [9:0]          point,
	input  wire [2:0]          dim,
	input  wire [4:0]          level_exp,
	input  wire [15:0]         grid_index,
	input  wire signed [31:0]  weight,
	input  wire [16:0]         coord,
	input  wire                last_dim,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [47:0] result_value,
	output logic [15:0]        result_number,
	input  wire                cfg_we,
	input  wire [1:0]          cfg_index,
	input  wire [10:0]         cfg_data
);
	import sghb_pkg::*;

	sghb_cmd_t cmd;
	sghb_sts_t sts;

	// Sequencer.
	sghb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.point     (point),
		.last_dim  (last_dim),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Storage and arithmetic.
	sghb_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.point         (point),
		.dim           (dim),
		.level_exp     (level_exp),
		.grid_index    (grid_index),
		.weight        (weight),
		.coord         (coord),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_value  (result_value),
		.result_number (result_number)
	);

endmodule
`default_nettype wire

/* rtl/core/sghb_checker.sv */
// Port level checks of the hat basis unit and their binding to the top level.
`default_nettype none
module sghb_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire [1:0]         mode,
	input wire               out_valid,
	input wire               out_stall,
	input wire signed [47:0] result_value
);
	import sghb_pkg::*;

	// A stalled result transaction stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_value))
		else $error("result changed while stalled");

	// A read-clear transaction occupies the unit in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_RDCLR |=> in_stall)
		else $error("read-clear did not occupy the unit");

	// A table load never makes a result appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == MODE_GRID || mode == MODE_SURPLUS)
			&& !out_valid |=> !out_valid)
		else $error("table load produced a result");

endmodule

bind sparse_grid_hat_basis_mult_unit sghb_checker u_sghb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.mode         (mode),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value)
);
`default_nettype wire
